@@ hw/rtl/date_string_to_day_count_core_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the date text to day count core
// Shared assertion forms for the checker, with and without the reset guard.
// ----------------------------------------------------------------------------
`ifndef DATE_STRING_TO_DAY_COUNT_CORE_ASSERT_SVH
`define DATE_STRING_TO_DAY_COUNT_CORE_ASSERT_SVH

// Check on every rising clock edge, ignored while reset is active.
`define DSDC_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Check on every rising clock edge, reset included.
`define DSDC_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ hw/rtl/dsdc_pkg.sv @@
// ----------------------------------------------------------------------------
// dsdc_pkg
// Types, constants and calendar tables shared by the date parser blocks.
// ----------------------------------------------------------------------------
package dsdc_pkg;

	localparam int YEAR_BITS_DEF   = 16;
	localparam int CHAR_W          = 8;
	localparam int DAY_COUNT_W     = 25;
	localparam int YEAR_VALUE_W    = 16;
	localparam int MONTH_W         = 4;
	localparam int DAY_W           = 5;
	localparam int STATUS_W        = 4;
	localparam int MON_ACC_W       = 5;
	localparam int DAY_ACC_W       = 6;
	localparam int DAYS_PER_YEAR   = 365;
	localparam int MONTHS_PER_YEAR = 12;

	localparam logic [CHAR_W-1:0] DOT_CHAR   = 8'h2E;
	localparam logic [CHAR_W-1:0] DIGIT_ZERO = 8'h30;
	localparam logic [CHAR_W-1:0] DIGIT_NINE = 8'h39;

	// Parse phase, one-hot.
	typedef enum logic [3:0] {
		PH_YEAR  = 4'b0001,
		PH_MONTH = 4'b0010,
		PH_DAY   = 4'b0100,
		PH_HALT  = 4'b1000
	} phase_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK             = 4'd0,
		ST_NO_YEAR        = 4'd1,
		ST_BAD_YEAR       = 4'd2,
		ST_BAD_AFTER_YEAR = 4'd3,
		ST_NO_MONTH       = 4'd4,
		ST_BAD_MONTH      = 4'd5,
		ST_BAD_AFTER_MON  = 4'd6,
		ST_NO_DAY         = 4'd7,
		ST_BAD_DAY        = 4'd8,
		ST_TRAILING       = 4'd9
	} status_t;

	// Control part of the parser state touched when a field closes.
	typedef struct packed {
		phase_t  ph;
		logic    seen;
		status_t err;
	} close_t;

	// Final parse of one string, handed to the conversion stage.
	typedef struct packed {
		logic [MON_ACC_W-1:0] month_acc;
		logic [DAY_ACC_W-1:0] day_acc;
		status_t              status;
	} snap_t;

	function automatic logic [4:0] month_len(input logic [MON_ACC_W-1:0] m);
		logic [4:0] len;
		case (m)
			5'd1:    len = 5'd31;
			5'd2:    len = 5'd28;
			5'd3:    len = 5'd31;
			5'd4:    len = 5'd30;
			5'd5:    len = 5'd31;
			5'd6:    len = 5'd30;
			5'd7:    len = 5'd31;
			5'd8:    len = 5'd31;
			5'd9:    len = 5'd30;
			5'd10:   len = 5'd31;
			5'd11:   len = 5'd30;
			5'd12:   len = 5'd31;
			default: len = 5'd0;
		endcase
		return len;
	endfunction

	function automatic logic [8:0] days_before(input logic [MONTH_W-1:0] m);
		logic [8:0] days;
		case (m)
			4'd1:    days = 9'd0;
			4'd2:    days = 9'd31;
			4'd3:    days = 9'd59;
			4'd4:    days = 9'd90;
			4'd5:    days = 9'd120;
			4'd6:    days = 9'd151;
			4'd7:    days = 9'd181;
			4'd8:    days = 9'd212;
			4'd9:    days = 9'd243;
			4'd10:   days = 9'd273;
			4'd11:   days = 9'd304;
			4'd12:   days = 9'd334;
			default: days = 9'd0;
		endcase
		return days;
	endfunction

	function automatic logic month_ok(input logic [MON_ACC_W-1:0] m);
		return (m != '0) && (m <= MON_ACC_W'(MONTHS_PER_YEAR));
	endfunction

	function automatic logic day_ok(input logic [MON_ACC_W-1:0] m,
			input logic [DAY_ACC_W-1:0] d);
		return month_ok(m) && (d != '0) && (d <= DAY_ACC_W'(month_len(m)));
	endfunction

	// End of a field's digit run: check it and pick the next phase or error.
	function automatic close_t close_field(input close_t s, input logic year_ovf,
			input logic mon_good, input logic day_good, input logic at_end,
			input logic dot);
		close_t r;
		r = s;
		case (s.ph)
			PH_YEAR: begin
				if (!s.seen) begin
					r.ph = PH_HALT; r.err = ST_NO_YEAR;
				end else if (year_ovf) begin
					r.ph = PH_HALT; r.err = ST_BAD_YEAR;
				end else if (at_end) begin
					r.ph = PH_HALT;
				end else if (dot) begin
					r.ph = PH_MONTH; r.seen = 1'b0;
				end else begin
					r.ph = PH_HALT; r.err = ST_BAD_AFTER_YEAR;
				end
			end
			PH_MONTH: begin
				if (!s.seen) begin
					r.ph = PH_HALT; r.err = ST_NO_MONTH;
				end else if (!mon_good) begin
					r.ph = PH_HALT; r.err = ST_BAD_MONTH;
				end else if (at_end) begin
					r.ph = PH_HALT;
				end else if (dot) begin
					r.ph = PH_DAY; r.seen = 1'b0;
				end else begin
					r.ph = PH_HALT; r.err = ST_BAD_AFTER_MON;
				end
			end
			PH_DAY: begin
				if (!s.seen) begin
					r.ph = PH_HALT; r.err = ST_NO_DAY;
				end else if (!day_good) begin
					r.ph = PH_HALT; r.err = ST_BAD_DAY;
				end else if (at_end) begin
					r.ph = PH_HALT;
				end else begin
					r.ph = PH_HALT; r.err = ST_TRAILING;
				end
			end
			default: begin
				r = s;
			end
		endcase
		return r;
	endfunction

endpackage

@@ hw/rtl/date_string_to_day_count_core.sv @@
// ----------------------------------------------------------------------------
// date_string_to_day_count_core
// Parses YYYY.MM.DD text, one character per transfer, into a 365-day count.
// ----------------------------------------------------------------------------
// The core takes one character per clock while char_stall is low and returns
// one result for every character transfer that carries last_char, through
// stage one and the result register. Month and day are optional. Parsing
// stops at the first error and the rest of the string is skipped up to its
// last character. The result gives the day count (year*365 + days before the
// month + day - 1), the year, month and day after fallbacks, and a status
// code; a missing or overflowing year gives all zero counts, a bad month
// forces month and day to 1, a bad day forces the day to 1. The next string
// can start in the cycle right after the last character of the previous one.
// Throughput is one character per cycle while char_stall is low; the
// per-character digit update and the year-by-365 multiply in the conversion
// stage set the cycle time. A result waiting on result_stall holds the
// conversion stage, and a full conversion stage raises char_stall.
// ----------------------------------------------------------------------------
module date_string_to_day_count_core import dsdc_pkg::*; #(
	parameter int YEAR_BITS = YEAR_BITS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,

	// character channel
	input  logic                     char_valid,
	output logic                     char_stall,
	input  logic [CHAR_W-1:0]        char_code,
	input  logic                     last_char,

	// result channel
	output logic                     result_valid,
	input  logic                     result_stall,
	output logic [DAY_COUNT_W-1:0]   day_count,
	output logic [YEAR_VALUE_W-1:0]  year_value,
	output logic [MONTH_W-1:0]       month_value,
	output logic [DAY_W-1:0]         day_value,
	output logic [STATUS_W-1:0]      status
);

	logic                 char_xfer;
	logic                 take;
	logic                 valid_s1;
	logic [YEAR_BITS:0]   year_s1;
	snap_t                snap_s1;

	// Stall characters only while a finished parse waits in stage one and the
	// result register cannot take it; otherwise take a character every cycle.
	assign char_stall = valid_s1 && !take;
	assign char_xfer  = char_valid && !char_stall;

	// Parse state advances on each character transfer; on the last character
	// the finished parse drops into stage one and the state clears for the
	// next string.
	dsdc_parser #(
		.YEAR_BITS (YEAR_BITS)
	) u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (char_xfer),
		.char_code (char_code),
		.last_char (last_char),
		.take      (take),
		.valid_s1  (valid_s1),
		.year_s1   (year_s1),
		.snap_s1   (snap_s1)
	);

	// Apply fallbacks, form the day count and hold it in the result register
	// until the result transfer.
	dsdc_convert #(
		.YEAR_BITS (YEAR_BITS)
	) u_convert (
		.clk          (clk),
		.arst_n       (arst_n),
		.valid_s1     (valid_s1),
		.year_s1      (year_s1),
		.snap_s1      (snap_s1),
		.result_stall (result_stall),
		.take         (take),
		.result_valid (result_valid),
		.day_count    (day_count),
		.year_value   (year_value),
		.month_value  (month_value),
		.day_value    (day_value),
		.status       (status)
	);

endmodule

@@ hw/rtl/dsdc_parser.sv @@
// ----------------------------------------------------------------------------
// dsdc_parser
// Character-by-character parse state and the first pipeline stage that holds
// the finished parse of a string.
// ----------------------------------------------------------------------------
module dsdc_parser import dsdc_pkg::*; #(
	parameter int YEAR_BITS = YEAR_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                accept,
	input  logic [CHAR_W-1:0]   char_code,
	input  logic                last_char,
	input  logic                take,
	output logic                valid_s1,
	output logic [YEAR_BITS:0]  year_s1,
	output snap_t               snap_s1
);

	localparam int YPW = YEAR_BITS + 5;
	localparam logic [YPW-1:0] YEAR_CAP = YPW'(1) << YEAR_BITS;

	phase_t                 phase_q;
	logic [YEAR_BITS:0]     year_q;
	logic [MON_ACC_W-1:0]   month_q;
	logic [DAY_ACC_W-1:0]   day_q;
	logic                   seen_q;
	status_t                err_q;

	logic                   is_digit;
	logic [3:0]             digit;
	logic [YPW-1:0]         ypush;
	logic [8:0]             mpush;
	logic [9:0]             dpush;
	logic [YEAR_BITS:0]     ysat;
	logic [MON_ACC_W-1:0]   msat;
	logic [DAY_ACC_W-1:0]   dsat;
	close_t                 c0;
	close_t                 c1;
	close_t                 c2;
	logic [YEAR_BITS:0]     y1;
	logic [MON_ACC_W-1:0]   m1;
	logic [DAY_ACC_W-1:0]   d1;

	assign is_digit = (char_code >= DIGIT_ZERO) && (char_code <= DIGIT_NINE);
	assign digit    = 4'(char_code - DIGIT_ZERO);

	// acc*10 + digit as two shifted copies, then saturate
	assign ypush = YPW'({year_q, 3'b000}) + YPW'({year_q, 1'b0}) + YPW'(digit);
	assign mpush = 9'({month_q, 3'b000}) + 9'({month_q, 1'b0}) + 9'(digit);
	assign dpush = 10'({day_q, 3'b000}) + 10'({day_q, 1'b0}) + 10'(digit);
	assign ysat  = (ypush > YEAR_CAP) ? YEAR_CAP[YEAR_BITS:0] : ypush[YEAR_BITS:0];
	assign msat  = (mpush > 9'd31) ? 5'd31 : mpush[MON_ACC_W-1:0];
	assign dsat  = (dpush > 10'd63) ? 6'd63 : dpush[DAY_ACC_W-1:0];

	assign c0 = '{ph: phase_q, seen: seen_q, err: err_q};

	always_comb begin
		c1 = c0;
		y1 = year_q;
		m1 = month_q;
		d1 = day_q;
		if (phase_q != PH_HALT) begin
			if (is_digit) begin
				c1.seen = 1'b1;
				case (phase_q)
					PH_YEAR:  y1 = ysat;
					PH_MONTH: m1 = msat;
					PH_DAY:   d1 = dsat;
					default:  y1 = year_q;
				endcase
			end else begin
				c1 = close_field(c0, year_q[YEAR_BITS], month_ok(month_q),
					day_ok(month_q, day_q), 1'b0, char_code == DOT_CHAR);
			end
		end
		// end of string closes whatever field is still open
		c2 = close_field(c1, y1[YEAR_BITS], month_ok(m1), day_ok(m1, d1), 1'b1, 1'b0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_YEAR;
			year_q  <= '0;
			month_q <= '0;
			day_q   <= '0;
			seen_q  <= 1'b0;
			err_q   <= ST_OK;
		end else if (accept) begin
			if (last_char) begin
				phase_q <= PH_YEAR;
				year_q  <= '0;
				month_q <= '0;
				day_q   <= '0;
				seen_q  <= 1'b0;
				err_q   <= ST_OK;
			end else begin
				phase_q <= c1.ph;
				year_q  <= y1;
				month_q <= m1;
				day_q   <= d1;
				seen_q  <= c1.seen;
				err_q   <= c1.err;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept && last_char) begin
			valid_s1 <= 1'b1;
		end else if (take) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && last_char) begin
			year_s1           <= y1;
			snap_s1.month_acc <= m1;
			snap_s1.day_acc   <= d1;
			snap_s1.status    <= c2.err;
		end
	end

endmodule

@@ hw/rtl/dsdc_convert.sv @@
// ----------------------------------------------------------------------------
// dsdc_convert
// Applies the fallbacks for bad fields and forms the 365-day count into the
// result register.
// ----------------------------------------------------------------------------
module dsdc_convert import dsdc_pkg::*; #(
	parameter int YEAR_BITS = YEAR_BITS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     valid_s1,
	input  logic [YEAR_BITS:0]       year_s1,
	input  snap_t                    snap_s1,
	input  logic                     result_stall,
	output logic                     take,
	output logic                     result_valid,
	output logic [DAY_COUNT_W-1:0]   day_count,
	output logic [YEAR_VALUE_W-1:0]  year_value,
	output logic [MONTH_W-1:0]       month_value,
	output logic [DAY_W-1:0]         day_value,
	output logic [STATUS_W-1:0]      status
);

	localparam int YW = YEAR_BITS + 1;
	localparam int CW = YW + 10;

	logic                          out_free;
	logic                          year_err;
	logic [YW-1:0]                 year_eff;
	logic [MONTH_W-1:0]            mon_eff;
	logic [DAY_W-1:0]              day_eff;
	logic [CW-1:0]                 count;
	logic [CW+DAY_COUNT_W-1:0]     count_ext;
	logic [YW+YEAR_VALUE_W-1:0]    year_ext;

	logic                          result_valid_q;
	logic [DAY_COUNT_W-1:0]        count_q;
	logic [YEAR_VALUE_W-1:0]       year_q;
	logic [MONTH_W-1:0]            month_q;
	logic [DAY_W-1:0]              day_q;
	logic [STATUS_W-1:0]           status_q;

	assign out_free = !result_valid_q || !result_stall;
	assign take     = valid_s1 && out_free;

	assign year_err = (snap_s1.status == ST_NO_YEAR) || (snap_s1.status == ST_BAD_YEAR);
	assign year_eff = year_err ? '0 : year_s1;
	assign mon_eff  = month_ok(snap_s1.month_acc) ? snap_s1.month_acc[MONTH_W-1:0] : 4'd1;
	assign day_eff  = day_ok(snap_s1.month_acc, snap_s1.day_acc) ?
		snap_s1.day_acc[DAY_W-1:0] : 5'd1;

	assign count = CW'(year_eff) * CW'(DAYS_PER_YEAR) + CW'(days_before(mon_eff))
		+ CW'(day_eff) - CW'(1);

	// zero-extend then trim to the port widths
	assign count_ext = {{DAY_COUNT_W{1'b0}}, count};
	assign year_ext  = {{YEAR_VALUE_W{1'b0}}, year_eff};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (out_free) begin
			result_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			count_q  <= count_ext[DAY_COUNT_W-1:0];
			year_q   <= year_ext[YEAR_VALUE_W-1:0];
			month_q  <= mon_eff;
			day_q    <= day_eff;
			status_q <= snap_s1.status;
		end
	end

	assign result_valid = result_valid_q;
	assign day_count    = count_q;
	assign year_value   = year_q;
	assign month_value  = month_q;
	assign day_value    = day_q;
	assign status       = status_q;

endmodule

@@ hw/rtl/dsdc_checker.sv @@
// ----------------------------------------------------------------------------
// dsdc_checker
// Port-level checks for the date text to day count core, bound to the top.
// ----------------------------------------------------------------------------
`include "date_string_to_day_count_core_assert.svh"

module dsdc_checker import dsdc_pkg::*; (
	input logic                     clk,
	input logic                     arst_n,
	input logic                     char_valid,
	input logic                     char_stall,
	input logic                     last_char,
	input logic                     result_valid,
	input logic                     result_stall,
	input logic [DAY_COUNT_W-1:0]   day_count,
	input logic [YEAR_VALUE_W-1:0]  year_value,
	input logic [MONTH_W-1:0]       month_value,
	input logic [DAY_W-1:0]         day_value,
	input logic [STATUS_W-1:0]      status
);

	localparam int RES_W = DAY_COUNT_W + YEAR_VALUE_W + MONTH_W + DAY_W + STATUS_W;

	logic             char_xfer;
	logic             last_xfer;
	logic [RES_W-1:0] result_bits;
	logic             year_zeroed;
	logic             result_in_range;

	assign char_xfer = char_valid && !char_stall;
	assign last_xfer = char_xfer && last_char;

	assign result_bits = {day_count, year_value, month_value, day_value, status};

	assign year_zeroed = ((status != ST_NO_YEAR) && (status != ST_BAD_YEAR)) ||
		((day_count == '0) && (year_value == '0));
	assign result_in_range = (month_value != '0) &&
		(month_value <= MONTH_W'(MONTHS_PER_YEAR)) && (day_value != '0) &&
		(status <= ST_TRAILING) && year_zeroed;

	// hold a stalled result
	`DSDC_ASSERT(a_result_held, result_valid && result_stall |=> result_valid, "stalled result dropped")
	`DSDC_ASSERT(a_result_stable, result_valid && result_stall |=> $stable(result_bits), "stalled result changed")

	// a fresh result traces back to a last-character transfer through stage one and the result register
	`DSDC_ASSERT(a_result_origin, $rose(result_valid) |-> $past(last_xfer, 2), "result without last character")

	// input backpressure only comes from a stalled result
	`DSDC_ASSERT_ALWAYS(a_stall_cause, char_stall |-> result_valid && result_stall, "char stall without result stall")

	// fallback values stay in range and a year error zeroes the count
	`DSDC_ASSERT(a_result_range, result_valid |-> result_in_range, "result field out of range")

endmodule

bind date_string_to_day_count_core dsdc_checker u_dsdc_checker (.*);
